@@ hdl/anagram_check_defines.svh @@
// Assertion macros for the anagram checker.
// Depends on nothing; included by the top level, which supplies clk and rst.
`ifndef ANAGRAM_CHECK_DEFINES_SVH
`define ANAGRAM_CHECK_DEFINES_SVH

`ifndef SYNTHESIS
// Checked outside reset.
`define ANAG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every edge, reset included.
`define ANAG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ANAG_ASSERT(lbl, prop, msg)
`define ANAG_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ hdl/anag_pkg.sv @@
// Shared types, constants and helpers of the anagram checker.
// Depends on nothing; used by the controller, the datapath and the top level.
package anag_pkg;

  // Length limit on the kept bytes of one string.
  localparam int unsigned LenW = 17;
  localparam logic [LenW-1:0] MAX_LEN = 17'd65535;

  // Histogram entries hold a signed count within +-MAX_LEN.
  localparam int unsigned CountW = 17;
  localparam int unsigned NzW = 9;

  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] UPPER_A = 8'h41;
  localparam logic [7:0] UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_RESULT
  } anag_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // latch a word and start the histogram read
    logic update;  // write the entry back and update the counters
    logic clear;   // verdict taken: start a new pair
  } anag_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;    // the word in flight ends the pair
  } anag_stat_t;

  // Fold the letters A-Z to lower case; every other byte passes unchanged.
  function automatic logic [7:0] fold_case(input logic [7:0] b);
    if (b >= UPPER_A && b <= UPPER_Z) begin
      return b + CASE_OFFSET;
    end
    return b;
  endfunction

endpackage

@@ hdl/anag_ctrl.sv @@
// Controller state machine of the anagram checker.
// Depends on anag_pkg; drives the handshakes and the datapath commands.
module anag_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  anag_pkg::anag_stat_t stat,
  output anag_pkg::anag_cmd_t  cmd
);
  import anag_pkg::*;

  anag_state_t state;
  anag_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_next = stat.last ? ST_RESULT : ST_IDLE;
      end
      ST_RESULT: begin
        if (m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
      end
      ST_RESULT: begin
        m_tvalid  = 1'b1;
        cmd.clear = m_tready;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

@@ hdl/anag_datapath.sv @@
// Datapath of the anagram checker: difference histogram memory, per-entry
// valid bits, nonzero counter and string lengths. Depends on anag_pkg.
module anag_datapath (
  input  logic                clk,
  input  logic                rst,
  input  anag_pkg::anag_cmd_t  cmd,
  input  logic [7:0]          char_byte,
  input  logic                which_string,
  input  logic                is_last,
  output anag_pkg::anag_stat_t stat,
  output logic                is_perm,
  output logic                too_long
);
  import anag_pkg::*;

  logic signed [CountW-1:0] hist [256];
  logic signed [CountW-1:0] rd_data;
  logic [255:0]             valid;

  logic [7:0]               addr;
  logic                     second;
  logic                     last;
  logic                     add_en;

  logic [NzW-1:0]           nonzero;
  logic [LenW-1:0]          len_first;
  logic [LenW-1:0]          len_second;

  logic [7:0]               folded;
  logic                     keep;
  logic [LenW-1:0]          len_sel;
  logic signed [CountW-1:0] old_count;
  logic signed [CountW-1:0] new_count;

  // Fold the incoming word and pick the length of its string.
  assign folded  = fold_case(char_byte);
  assign keep    = (char_byte != SPACE_CHAR);
  assign len_sel = which_string ? len_second : len_first;

  // Latch the word in flight.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr   <= folded;
      second <= which_string;
      last   <= is_last;
      add_en <= keep && (len_sel < MAX_LEN);
    end
  end

  // Histogram memory: read on load, write back on update.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_data <= hist[folded];
    end
    if (cmd.update && add_en) begin
      hist[addr] <= new_count;
    end
  end

  // Entries not written in this pair read as zero.
  assign old_count = valid[addr] ? rd_data : '0;
  assign new_count = second ? (old_count - CountW'(1)) : (old_count + CountW'(1));

  // Valid bits and nonzero entry counter.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      valid   <= '0;
      nonzero <= '0;
    end else if (cmd.update && add_en) begin
      valid[addr] <= 1'b1;
      if (old_count == '0) begin
        nonzero <= nonzero + NzW'(1);
      end else if (new_count == '0) begin
        nonzero <= nonzero - NzW'(1);
      end
    end
  end

  // Saturating lengths: a string stops counting one past the limit.
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      len_first  <= '0;
      len_second <= '0;
    end else if (cmd.load && keep && (len_sel <= MAX_LEN)) begin
      if (which_string) begin
        len_second <= len_second + LenW'(1);
      end else begin
        len_first <= len_first + LenW'(1);
      end
    end
  end

  // Verdict, stable while the result waits.
  assign too_long  = (len_first > MAX_LEN) || (len_second > MAX_LEN);
  assign is_perm   = !too_long && (nonzero == '0);
  assign stat.last = last;

endmodule

@@ hdl/anagram_check.sv @@
// Top level of the anagram checker: joins the controller and the datapath.
// Depends on anag_pkg, anag_ctrl, anag_datapath and anagram_check_defines.svh.
//
//  channel  | direction | tdata                      | tuser        | tlast
//  ---------+-----------+----------------------------+--------------+--------
//  s_*      | in        | [7:0] char_byte            | which_string | is_last
//  m_*      | out       | [0] is_perm, [1] too_long  | -            | -
//
// Each word is accepted in ST_IDLE, which reads its histogram entry from
// the single-port memory; ST_UPDATE writes it back and updates the counters.
// A word that ends the pair then leads to ST_RESULT, whose verdict holds
// until m_tready; then the pair state clears in that cycle.
// Reset clears the 256 entry valid bits at once; no clearing pass follows.
// No word is accepted while a verdict waits.
`include "anagram_check_defines.svh"

module anagram_check (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_byte
  input  logic       s_tuser,   // [0] which_string
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] is_perm, [1] too_long, [7:2] zero
);
  import anag_pkg::*;

  anag_cmd_t  cmd;
  anag_stat_t stat;
  logic       is_perm;
  logic       too_long;

  anag_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  anag_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .char_byte    (s_tdata),
    .which_string (s_tuser),
    .is_last      (s_tlast),
    .stat         (stat),
    .is_perm      (is_perm),
    .too_long     (too_long)
  );

  assign m_tdata = {6'b0, too_long, is_perm};

  // Input and output are never open together.
  `ANAG_ASSERT(a_excl, !(s_tready && m_tvalid), "input ready while a verdict waits")
  // A final word yields a verdict once its update state has passed.
  `ANAG_ASSERT(a_verdict, (s_tvalid && s_tready && s_tlast) |=> ##1 m_tvalid, "no verdict")
  // Taking the verdict returns the block to accepting words.
  `ANAG_ASSERT(a_resume, (m_tvalid && m_tready) |=> s_tready, "no resume after verdict")
  // Reset leaves the block ready with no result pending.
  `ANAG_ASSERT_ALWAYS(a_reset, rst |=> (s_tready && !m_tvalid), "bad state after reset")

endmodule

@@ verif/anagram_check_test.sv @@
// Self-checking testbench for anagram_check: streams tagged string bytes and
// checks every verdict against a histogram predictor kept in the bench.
// Depends on anag_pkg and the anagram_check RTL; reads no files.
module anagram_check_test;
  timeunit 1ns;
  timeprecision 1ps;

  import anag_pkg::*;

  localparam logic [7:0] LOWER_A = 8'h61;
  localparam logic [7:0] LOWER_Z = 8'h7A;
  localparam int RandomWordsPerPhase = 250;
  localparam int SettleCycles = 10;

  // One word on the input stream.
  typedef struct packed {
    logic [7:0] ch;
    logic       str_sel;
    logic       ends_pair;
  } char_word_t;

  // One verdict on the output stream.
  typedef struct packed {
    logic is_perm;
    logic too_long;
  } verdict_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tuser = 1'b0;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;

  char_word_t pending_words[$];
  verdict_t   expected_verdicts[$];
  int         queued_cnt = 0;
  int         accepted_cnt = 0;
  int         verdict_cnt = 0;
  int         mismatch_cnt = 0;
  int         tx_idle_pct = 8;
  int         rx_idle_pct = 55;

  // Predictor state: per-character balance, nonzero entry count, kept lengths.
  int         char_balance[256];
  int         nonzero_cnt = 0;
  int         kept_len[2];

  anagram_check u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // Histogram predictor: applies one accepted word, queues a verdict at pair end.
  function automatic void predict_word(input logic [7:0] ch, input logic str_sel,
                                       input logic ends_pair);
    logic [7:0] key;
    int         prev;
    int         next;
    verdict_t   v;
    if (ch != SPACE_CHAR) begin
      key = ch;
      if (ch >= UPPER_A && ch <= UPPER_Z) begin
        key = ch + CASE_OFFSET;
      end
      // Length saturates one past the limit; bytes past the limit are not counted.
      if (kept_len[str_sel] <= int'(MAX_LEN)) begin
        kept_len[str_sel]++;
        if (kept_len[str_sel] <= int'(MAX_LEN)) begin
          prev = char_balance[key];
          next = str_sel ? prev - 1 : prev + 1;
          if (prev == 0) nonzero_cnt++;
          if (next == 0) nonzero_cnt--;
          char_balance[key] = next;
        end
      end
    end
    if (ends_pair) begin
      v.too_long = (kept_len[0] > int'(MAX_LEN)) || (kept_len[1] > int'(MAX_LEN));
      v.is_perm = !v.too_long && (nonzero_cnt == 0);
      expected_verdicts.push_back(v);
      foreach (char_balance[i]) char_balance[i] = 0;
      nonzero_cnt = 0;
      kept_len[0] = 0;
      kept_len[1] = 0;
    end
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endfunction

  // Compares one delivered verdict with the oldest expectation.
  function automatic void check_verdict(input logic [7:0] got);
    verdict_t want;
    if (expected_verdicts.size() == 0) begin
      note_mismatch($sformatf("verdict 0x%02h with none expected", got));
      return;
    end
    want = expected_verdicts.pop_front();
    if (got[0] !== want.is_perm) begin
      note_mismatch($sformatf("verdict %0d is_perm expected %0b got %b",
                              verdict_cnt, want.is_perm, got[0]));
    end
    if (got[1] !== want.too_long) begin
      note_mismatch($sformatf("verdict %0d too_long expected %0b got %b",
                              verdict_cnt, want.too_long, got[1]));
    end
    if (got[7:2] !== 6'd0) begin
      note_mismatch($sformatf("verdict %0d padding expected 0 got %b",
                              verdict_cnt, got[7:2]));
    end
    verdict_cnt++;
  endfunction

  // Monitor: predicts on every accepted word and checks every accepted verdict.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict_word(s_tdata, s_tuser, s_tlast);
        accepted_cnt++;
      end
      if (m_tvalid && m_tready) begin
        check_verdict(m_tdata);
      end
    end
  end

  // Driver: presents the next pending word, idling at random.
  always @(posedge clk) begin
    char_word_t w;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        w = pending_words.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= w.ch;
        s_tuser <= w.str_sel;
        s_tlast <= w.ends_pair;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stalls at random.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  function automatic void add_word(input logic [7:0] ch, input logic str_sel,
                                   input logic ends_pair);
    char_word_t w;
    w.ch = ch;
    w.str_sel = str_sel;
    w.ends_pair = ends_pair;
    pending_words.push_back(w);
    queued_cnt++;
  endfunction

  // Mostly letters of either case, some spaces, the rest any byte.
  function automatic logic [7:0] random_char();
    int pick;
    pick = $urandom_range(9);
    if (pick < 4) return LOWER_A + 8'($urandom_range(25));
    if (pick < 6) return UPPER_A + 8'($urandom_range(25));
    if (pick == 6) return SPACE_CHAR;
    return 8'($urandom_range(255));
  endfunction

  // Queues one pair: usually a case-shuffled permutation, sometimes broken or noise.
  // Returns the number of words queued.
  function automatic int queue_random_pair();
    logic [7:0] first_str[$];
    logic [7:0] second_str[$];
    logic [7:0] ch;
    int         len_n;
    int         kind;
    int         j;
    int         words;
    int         sequential;
    logic       take_second;
    len_n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(10);
    for (int i = 0; i < len_n; i++) first_str.push_back(random_char());
    kind = $urandom_range(9);
    if (kind == 9) begin
      // Noise: two unrelated strings.
      len_n = $urandom_range(10);
      for (int i = 0; i < len_n; i++) second_str.push_back(8'($urandom_range(255)));
    end else begin
      second_str = first_str;
      for (int i = second_str.size() - 1; i > 0; i--) begin
        j = $urandom_range(i);
        ch = second_str[i];
        second_str[i] = second_str[j];
        second_str[j] = ch;
      end
      // Flip the case of letters at random.
      foreach (second_str[i]) begin
        if ($urandom_range(1)) begin
          if (second_str[i] >= LOWER_A && second_str[i] <= LOWER_Z) begin
            second_str[i] = second_str[i] - CASE_OFFSET;
          end else if (second_str[i] >= UPPER_A && second_str[i] <= UPPER_Z) begin
            second_str[i] = second_str[i] + CASE_OFFSET;
          end
        end
      end
      if ($urandom_range(2) == 0) begin
        second_str.insert($urandom_range(second_str.size()), SPACE_CHAR);
      end
      // Break the permutation: change, drop or add one byte.
      if (kind == 7 && second_str.size() != 0) begin
        second_str[$urandom_range(second_str.size() - 1)] = random_char();
      end else if (kind == 8) begin
        if (second_str.size() != 0 && $urandom_range(1)) begin
          second_str.delete($urandom_range(second_str.size() - 1));
        end else begin
          second_str.insert($urandom_range(second_str.size()), random_char());
        end
      end
    end
    // Interleave the two strings, or send them one after the other.
    sequential = ($urandom_range(2) == 0);
    words = first_str.size() + second_str.size();
    if (words == 0) begin
      add_word(SPACE_CHAR, 1'($urandom_range(1)), 1'b1);
      return 1;
    end
    for (int k = 0; k < words; k++) begin
      if (first_str.size() == 0) take_second = 1'b1;
      else if (second_str.size() == 0) take_second = 1'b0;
      else if (sequential) take_second = 1'b0;
      else take_second = 1'($urandom_range(1));
      ch = take_second ? second_str.pop_front() : first_str.pop_front();
      add_word(ch, take_second, k == words - 1);
    end
    return words;
  endfunction

  task automatic queue_random_phase();
    int words;
    words = 0;
    while (words < RandomWordsPerPhase) words += queue_random_pair();
  endtask

  // Waits until every queued word is accepted and every verdict has arrived.
  task automatic wait_drained();
    @(negedge clk);
    while (accepted_cnt != queued_cnt || expected_verdicts.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Stimulus and end of run.
  initial begin
    foreach (char_balance[i]) char_balance[i] = 0;
    kept_len[0] = 0;
    kept_len[1] = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty pair as a lone space carrying the last flag.
    add_word(SPACE_CHAR, 1'b0, 1'b1);
    // Extreme byte values on both strings.
    add_word(8'h00, 1'b0, 1'b0);
    add_word(8'hFF, 1'b0, 1'b0);
    add_word(8'hFF, 1'b1, 1'b0);
    add_word(8'h00, 1'b1, 1'b1);
    // Case folding at both ends of the alphabet; the pair ends on a space.
    add_word(UPPER_A, 1'b0, 1'b0);
    add_word(LOWER_Z, 1'b0, 1'b0);
    add_word(LOWER_A, 1'b1, 1'b0);
    add_word(UPPER_Z, 1'b1, 1'b0);
    add_word(SPACE_CHAR, 1'b1, 1'b1);
    // Neighbors of the letter range are not folded.
    add_word(8'h40, 1'b0, 1'b0);
    add_word(8'h60, 1'b1, 1'b1);
    add_word(8'h5B, 1'b0, 1'b0);
    add_word(8'h7B, 1'b1, 1'b1);
    // High bytes, second string first.
    add_word(8'h80, 1'b1, 1'b0);
    add_word(8'h80, 1'b0, 1'b1);
    // Only one string present.
    add_word(8'h62, 1'b0, 1'b1);
    // Spaces inside the second string are dropped.
    add_word(8'h78, 1'b0, 1'b0);
    add_word(SPACE_CHAR, 1'b1, 1'b0);
    add_word(8'h58, 1'b1, 1'b1);

    // Sender rarely idles, receiver often stalls.
    queue_random_phase();
    wait_drained();

    // Sender often idles, receiver rarely stalls.
    tx_idle_pct = 55;
    rx_idle_pct = 8;
    queue_random_phase();
    wait_drained();

    // No idling: random pairs back to back.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    queue_random_phase();
    wait_drained();

    repeat (SettleCycles) @(negedge clk);
    if (mismatch_cnt == 0 && expected_verdicts.size() == 0) begin
      $display("anagram_check verification clean");
    end else begin
      $display("anagram_check verification failed");
    end
    $finish;
  end

  // Watchdog: several times the slowest correct run.
  initial begin
    #2_000_000;
    $display("anagram_check verification failed");
    $finish;
  end

endmodule
